// ===== sv/dgr_pkg.sv =====
`timescale 1ns / 1ps

package dgr_pkg;

  localparam int DEPTH_W = 8;
  localparam int COLOR_W = 8;
  localparam int CNT_W   = 7;
  localparam int MIN_W   = 9;
  localparam int DIV_W   = 9;
  localparam int DIFF_W  = 10;
  localparam int CFG_AW  = 3;
  localparam int CFG_DW  = 32;

  localparam logic [DEPTH_W-1:0] SEG1_START = 8'd85;
  localparam logic [DEPTH_W-1:0] SEG2_START = 8'd170;
  localparam logic [6:0]         SEG2_LEN   = 7'd86;
  localparam logic [MIN_W-1:0]   MIN_RESET  = 9'd256;
  localparam logic [CNT_W-1:0]   CNT_RESET  = 7'd10;

  localparam logic [COLOR_W-1:0] COLOR_FULL = 8'd255;
  localparam logic [COLOR_W-1:0] COLOR_NONE = 8'd0;

  localparam logic REQ_STATS = 1'b0;
  localparam logic REQ_COLOR = 1'b1;

  localparam logic [CFG_AW-3:0] REG_CONTOUR_COUNT = '0;

  typedef struct packed {
    logic stat_upd;
    logic pix_load;
    logic dif_start;
    logic pix_start;
    logic dif_store;
    logic res_load;
  } dgr_cmd_t;

  typedef struct packed {
    logic dirty;
    logic div_done;
    logic skip;
    logic out_free;
  } dgr_sts_t;

endpackage

// ===== sv/dgr_if.sv =====
`timescale 1ns / 1ps

interface dgr_in_if;
  import dgr_pkg::*;

  logic               valid;
  logic               ready;
  logic               req_type;
  logic [DEPTH_W-1:0] depth;
  logic               frame_start;

  modport source (output valid, req_type, depth, frame_start, input ready);
  modport sink (input valid, req_type, depth, frame_start, output ready);
endinterface

interface dgr_out_if;
  import dgr_pkg::*;

  logic               valid;
  logic               ready;
  logic [COLOR_W-1:0] red;
  logic [COLOR_W-1:0] green;
  logic [COLOR_W-1:0] blue;
  logic               on_contour;

  modport source (output valid, red, green, blue, on_contour, input ready);
  modport sink (input valid, red, green, blue, on_contour, output ready);
endinterface

// ===== sv/dgr_div.sv =====
`timescale 1ns / 1ps

module dgr_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [dgr_pkg::DIV_W-1:0]  dividend,
  input  logic [dgr_pkg::DIV_W-1:0]  divisor,
  output logic                       done,
  output logic [dgr_pkg::DIV_W-1:0]  quo,
  output logic [dgr_pkg::DIV_W-1:0]  rem
);
  import dgr_pkg::*;

  localparam int STEP_W = $clog2(DIV_W + 1);

  logic [STEP_W-1:0] step_r, step_nxt;
  logic              done_r, done_nxt;
  logic [DIV_W-1:0]  quo_r, quo_nxt;
  logic [DIV_W-1:0]  rem_r, rem_nxt;
  logic [DIV_W-1:0]  dvs_r, dvs_nxt;
  logic [DIV_W:0]    shifted;
  logic [DIV_W:0]    trial;

  // Restoring division, one quotient bit per cycle.
  assign shifted = {rem_r, quo_r[DIV_W-1]};
  assign trial   = shifted - {1'b0, dvs_r};

  always_comb begin
    step_nxt = step_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    dvs_nxt  = dvs_r;
    done_nxt = 1'b0;
    if (start) begin
      step_nxt = STEP_W'(DIV_W);
      quo_nxt  = dividend;
      rem_nxt  = '0;
      dvs_nxt  = divisor;
    end else if (step_r != '0) begin
      step_nxt = step_r - 1'b1;
      done_nxt = (step_r == STEP_W'(1));
      if (!trial[DIV_W]) begin
        rem_nxt = trial[DIV_W-1:0];
        quo_nxt = {quo_r[DIV_W-2:0], 1'b1};
      end else begin
        rem_nxt = shifted[DIV_W-1:0];
        quo_nxt = {quo_r[DIV_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= '0;
      done_r <= 1'b0;
    end else begin
      step_r <= step_nxt;
      done_r <= done_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
    dvs_r <= dvs_nxt;
  end

  assign done = done_r;
  assign quo  = quo_r;
  assign rem  = rem_r;

endmodule

// ===== sv/dgr_ctrl.sv =====
`timescale 1ns / 1ps

module dgr_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_req_type,
  output logic              in_ready,
  input  dgr_pkg::dgr_sts_t sts,
  output dgr_pkg::dgr_cmd_t cmd
);
  import dgr_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_CHECK,
    S_DIF,
    S_PIX,
    S_EMIT
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (in_req_type == REQ_STATS) begin
            cmd.stat_upd = 1'b1;
          end else begin
            cmd.pix_load = 1'b1;
            state_nxt    = S_CHECK;
          end
        end
      end
      S_CHECK: begin
        if (sts.dirty) begin
          cmd.dif_start = 1'b1;
          state_nxt     = S_DIF;
        end else if (sts.skip) begin
          state_nxt = S_EMIT;
        end else begin
          cmd.pix_start = 1'b1;
          state_nxt     = S_PIX;
        end
      end
      S_DIF: begin
        if (sts.div_done) begin
          cmd.dif_store = 1'b1;
          state_nxt     = S_CHECK;
        end
      end
      S_PIX: begin
        if (sts.div_done) begin
          state_nxt = S_EMIT;
        end
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.res_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign in_ready = (state_r == S_IDLE);

endmodule

// ===== sv/dgr_dp.sv =====
`timescale 1ns / 1ps

module dgr_dp (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic [dgr_pkg::DEPTH_W-1:0]  in_depth,
  input  logic                         in_frame_start,
  input  logic                         cfg_wr,
  input  logic [dgr_pkg::CNT_W-1:0]    cfg_wdata,
  output logic [dgr_pkg::CNT_W-1:0]    cnt,
  input  dgr_pkg::dgr_cmd_t            cmd,
  output dgr_pkg::dgr_sts_t            sts,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [dgr_pkg::COLOR_W-1:0]  out_red,
  output logic [dgr_pkg::COLOR_W-1:0]  out_green,
  output logic [dgr_pkg::COLOR_W-1:0]  out_blue,
  output logic                         out_on_contour
);
  import dgr_pkg::*;

  logic [MIN_W-1:0]   frame_min_r, frame_min_nxt;
  logic [DEPTH_W-1:0] frame_max_r, frame_max_nxt;
  logic [CNT_W-1:0]   cnt_r;
  logic               dirty_r, dirty_nxt;
  logic [DEPTH_W-1:0] depth_r;
  logic [DIV_W-1:0]   m_abs_r;
  logic               m_neg_r;
  logic               out_valid_r, out_valid_nxt;
  logic [COLOR_W-1:0] red_r, green_r, blue_r;
  logic               on_r;

  logic [MIN_W-1:0]   min_base;
  logic [DEPTH_W-1:0] max_base;

  logic [DIV_W-1:0]   div_a, div_b, quo, rem;
  logic               div_done;

  logic [DIFF_W-1:0]  span, a;
  logic [DIV_W-1:0]   span_abs, a_abs;
  logic               a_zero, skip, fast_hit, slow_hit, hit;

  logic [DEPTH_W-1:0] t;
  logic [COLOR_W-1:0] t3;
  logic [6:0]         u;
  logic [8:0]         u3, g2;
  logic [1:0]         corr;
  logic [COLOR_W-1:0] ramp_r, ramp_g, ramp_b;

  // Statistics update; a frame restart folds the sample into fresh bounds.
  always_comb begin
    min_base      = in_frame_start ? MIN_RESET : frame_min_r;
    max_base      = in_frame_start ? '0 : frame_max_r;
    frame_min_nxt = ({1'b0, in_depth} < min_base) ? {1'b0, in_depth} : min_base;
    frame_max_nxt = (in_depth > max_base) ? in_depth : max_base;
  end

  // Signed level spacing numerator and pixel offset from the frame minimum.
  assign span     = {2'b00, frame_max_r} - {1'b0, frame_min_r};
  assign span_abs = span[DIFF_W-1] ? DIV_W'(-span) : span[DIV_W-1:0];
  assign a        = {2'b00, depth_r} - {1'b0, frame_min_r};
  assign a_abs    = a[DIFF_W-1] ? DIV_W'(-a) : a[DIV_W-1:0];
  assign a_zero   = (a == '0);

  assign div_a = cmd.dif_start ? span_abs : a_abs;
  assign div_b = cmd.dif_start ? {{(DIV_W-CNT_W){1'b0}}, cnt_r} : m_abs_r;

  dgr_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.dif_start | cmd.pix_start),
    .dividend (div_a),
    .divisor  (div_b),
    .done     (div_done),
    .quo      (quo),
    .rem      (rem)
  );

  // A level is hit when the offset is a whole multiple k of the spacing with k < count.
  assign skip     = (cnt_r == '0) || (m_abs_r == '0) || a_zero ||
                    (a[DIFF_W-1] != m_neg_r);
  assign fast_hit = (cnt_r != '0) && a_zero;
  assign slow_hit = (rem == '0) && (quo < {{(DIV_W-CNT_W){1'b0}}, cnt_r});
  assign hit      = skip ? fast_hit : slow_hit;

  // Three segment ramp. The last segment is 86 long, so its green channel
  // is floor(255*u/86) = 3u - ceil(3u/86) with u = 86 - t.
  always_comb begin
    t      = depth_r;
    ramp_r = COLOR_NONE;
    ramp_g = COLOR_NONE;
    ramp_b = COLOR_NONE;
    if (depth_r < SEG1_START) begin
      t = depth_r;
    end else if (depth_r < SEG2_START) begin
      t = depth_r - SEG1_START;
    end else begin
      t = depth_r - SEG2_START;
    end
    t3   = COLOR_W'({t, 1'b0} + {1'b0, t});
    u    = SEG2_LEN - t[6:0];
    u3   = {1'b0, u, 1'b0} + {2'b00, u};
    corr = 2'd1 + {1'b0, (u >= 7'd29)} + {1'b0, (u >= 7'd58)};
    g2   = u3 - {7'd0, corr};
    if (depth_r < SEG1_START) begin
      ramp_g = t3;
      ramp_b = COLOR_FULL - t3;
    end else if (depth_r < SEG2_START) begin
      ramp_r = t3;
      ramp_g = COLOR_FULL;
    end else begin
      ramp_r = COLOR_FULL;
      ramp_g = g2[COLOR_W-1:0];
    end
  end

  always_comb begin
    dirty_nxt = dirty_r;
    if (cmd.dif_store) begin
      dirty_nxt = 1'b0;
    end
    if (cmd.stat_upd || cfg_wr) begin
      dirty_nxt = 1'b1;
    end
    out_valid_nxt = out_valid_r;
    if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (cmd.res_load) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_min_r <= MIN_RESET;
      frame_max_r <= '0;
      cnt_r       <= CNT_RESET;
      dirty_r     <= 1'b1;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.stat_upd) begin
        frame_min_r <= frame_min_nxt;
        frame_max_r <= frame_max_nxt;
      end
      if (cfg_wr) begin
        cnt_r <= cfg_wdata;
      end
      dirty_r     <= dirty_nxt;
      out_valid_r <= out_valid_nxt;
    end
    if (cmd.pix_load) begin
      depth_r <= in_depth;
    end
    // Spacing is trunc(span/count) + 1, kept as sign and magnitude.
    if (cmd.dif_store) begin
      if (!span[DIFF_W-1]) begin
        m_abs_r <= quo + 1'b1;
        m_neg_r <= 1'b0;
      end else if (quo == '0) begin
        m_abs_r <= DIV_W'(1);
        m_neg_r <= 1'b0;
      end else begin
        m_abs_r <= quo - 1'b1;
        m_neg_r <= (quo != DIV_W'(1));
      end
    end
    if (cmd.res_load) begin
      red_r   <= hit ? COLOR_NONE : ramp_r;
      green_r <= hit ? COLOR_NONE : ramp_g;
      blue_r  <= hit ? COLOR_NONE : ramp_b;
      on_r    <= hit;
    end
  end

  assign sts.dirty    = dirty_r;
  assign sts.div_done = div_done;
  assign sts.skip     = skip;
  assign sts.out_free = !out_valid_r || out_ready;

  assign cnt            = cnt_r;
  assign out_valid      = out_valid_r;
  assign out_red        = red_r;
  assign out_green      = green_r;
  assign out_blue       = blue_r;
  assign out_on_contour = on_r;

endmodule

// ===== sv/depth_gradient_relief_with_contours.sv =====
`timescale 1ns / 1ps

// Depth relief colorizer with contour lines.
// The input channel carries one depth sample per item. A statistics item
// (req_type 0) folds the depth into the frame minimum and maximum and gives
// no result; with frame_start set the bounds restart first. A color item
// (req_type 1) gives exactly one result item: a blue-green-yellow-red ramp
// color, or black with on_contour set when the depth lies on a contour level.
// Levels are spaced evenly between the frame bounds; contour_count, written
// over the APB port at byte address 0, sets how many there are.
// Statistics items are taken back to back. A color item waits for its result
// on the 9-step serial divider that checks the depth against the level spacing;
// when that check cannot hit (zero count or spacing, depth at the minimum or on
// the wrong side of it) the divider is skipped. After a statistics item or a
// register write the spacing itself is recomputed on that divider first.
// One item is worked on at a time. The result sits in an output register, so
// a stalled receiver holds only the next color item, and only at its end.
// Reset (synchronous, active low) restores the bounds to "no samples yet",
// the contour count to 10 and empties the output register.
module depth_gradient_relief_with_contours (
  input  logic                         clk,
  input  logic                         rst_n,
  dgr_in_if.sink                       in_ch,
  dgr_out_if.source                    out_ch,
  input  logic                         cfg_psel,
  input  logic                         cfg_penable,
  input  logic                         cfg_pwrite,
  input  logic [dgr_pkg::CFG_AW-1:0]   cfg_paddr,
  input  logic [dgr_pkg::CFG_DW-1:0]   cfg_pwdata,
  output logic [dgr_pkg::CFG_DW-1:0]   cfg_prdata,
  output logic                         cfg_pready
);
  import dgr_pkg::*;

  dgr_cmd_t         cmd;
  dgr_sts_t         sts;
  logic             cfg_hit;
  logic             cfg_wr;
  logic [CNT_W-1:0] cnt;

  // Only the word at offset zero is decoded; the low address bits select a
  // byte within it and are ignored.
  assign cfg_hit    = (cfg_paddr[CFG_AW-1:2] == REG_CONTOUR_COUNT);
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_hit;
  assign cfg_prdata = cfg_hit ? {{(CFG_DW-CNT_W){1'b0}}, cnt} : '0;

  dgr_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_ch.valid),
    .in_req_type (in_ch.req_type),
    .in_ready    (in_ch.ready),
    .sts         (sts),
    .cmd         (cmd)
  );

  dgr_dp u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_depth       (in_ch.depth),
    .in_frame_start (in_ch.frame_start),
    .cfg_wr         (cfg_wr),
    .cfg_wdata      (cfg_pwdata[CNT_W-1:0]),
    .cnt            (cnt),
    .cmd            (cmd),
    .sts            (sts),
    .out_valid      (out_ch.valid),
    .out_ready      (out_ch.ready),
    .out_red        (out_ch.red),
    .out_green      (out_ch.green),
    .out_blue       (out_ch.blue),
    .out_on_contour (out_ch.on_contour)
  );

endmodule
